@@ rtl/qxm_pkg.sv @@
// ----------------------------------------------------------------------------
// qxm_pkg
// Shared constants and types of the quadrotor X-frame motor mixer.
// ----------------------------------------------------------------------------
package qxm_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 31;
    localparam int SUM_W      = DATA_W + 2;
    localparam int LO_W       = (SUM_W + 1) / 2;
    localparam int HI_W       = SUM_W - LO_W;
    localparam int PART_W     = HI_W + GAIN_W + 1;
    localparam int PROD_W     = SUM_W + GAIN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_LANES  = 3;
    localparam int NUM_MOTORS = 4;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_DIAG_ARM     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_HALF_DIAG_ARM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_YAW_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRUST_FLOOR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRUST_CEILING    = 3'd5;

    localparam logic CMD_MIX   = 1'b0;
    localparam logic CMD_UNMIX = 1'b1;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic        [GAIN_W-1:0] t_gain;
    typedef logic signed [PART_W-1:0] t_part;
    typedef logic signed [PROD_W-1:0] t_prod;

    localparam t_gain GAIN_ONE = t_gain'(64'd1 << FRAC_BITS);

    localparam t_data DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam t_data FLOOR_RESET   = '0;
    localparam t_data CEILING_RESET = DATA_MAX;

    localparam t_prod PROD_DATA_MAX = {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam t_prod PROD_DATA_MIN = {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam t_sum  SUM_DATA_MAX  = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam t_sum  SUM_DATA_MIN  = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

endpackage

@@ rtl/quad_x_motor_mixer.sv @@
// ----------------------------------------------------------------------------
// quad_x_motor_mixer
// Quadrotor X-frame motor mixer in signed fixed point.
//
// The input channel (i_in_valid / o_in_ready) carries one word per item: a
// command bit and four signed operands. Command 0 mixes force, roll, pitch
// and yaw into four motor thrusts clamped to the floor and ceiling
// registers; command 1 maps four thrusts back to force and moments. The
// output channel (o_out_valid / i_out_ready) returns one word per item, in
// order. The configuration port writes one register per cycle when
// i_cfg_wr_en is high; it is to be written only while the mixer is empty,
// which the block itself does not enforce. The path is a five-stage
// pipeline: operand sums, split partial products, product recombination
// with saturation, four-term sums with division by four, and clamping into
// the output register. One word per cycle is accepted and delivered while
// the receiver keeps up. When the receiver stalls, each stage holds while
// its successor is full, so bubbles are squeezed out before o_in_ready
// drops. Reset empties the pipeline and loads the register defaults (unit
// gains, floor zero, ceiling at the largest positive value).
// ----------------------------------------------------------------------------
module quad_x_motor_mixer import qxm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic signed [31:0]   i_force_or_thrust_a,
    input  logic signed [31:0]   i_roll_or_thrust_b,
    input  logic signed [31:0]   i_pitch_or_thrust_c,
    input  logic signed [31:0]   i_yaw_or_thrust_d,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [31:0]   o_thrust_a_or_force,
    output logic signed [31:0]   o_thrust_b_or_roll,
    output logic signed [31:0]   o_thrust_c_or_pitch,
    output logic signed [31:0]   o_thrust_d_or_yaw,
    output logic [3:0]           o_clamp_flags,
    output logic                 o_overflow_flag
);

    t_gain r_half_diag_arm;
    t_gain r_inv_half_diag_arm;
    t_gain r_yaw_gain;
    t_gain r_inv_yaw_gain;
    t_data r_thrust_floor;
    t_data r_thrust_ceiling;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    logic  r1_cmd;
    t_sum  r1_base;
    t_sum  r1_opd  [NUM_LANES];
    t_gain r1_gain [NUM_LANES];
    t_sum  n1_base;
    t_sum  n1_opd  [NUM_LANES];
    t_gain n1_gain [NUM_LANES];

    logic  r2_cmd;
    t_sum  r2_base;
    t_part r2_ph [NUM_LANES];
    t_part r2_pl [NUM_LANES];

    logic  r3_cmd;
    t_sum  r3_base;
    t_data r3_prod [NUM_LANES];
    logic  r3_ovf;
    t_data n3_prod [NUM_LANES];
    logic  n3_ovf;

    logic  r4_cmd;
    t_data r4_raw [NUM_MOTORS];
    logic  r4_ovf;
    t_data n4_raw [NUM_MOTORS];
    logic  n4_ovf;

    t_data                 r5_out [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] r5_flags;
    logic                  r5_ovf;
    t_data                 n5_out [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] n5_flags;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_diag_arm     <= GAIN_ONE;
            r_inv_half_diag_arm <= GAIN_ONE;
            r_yaw_gain          <= GAIN_ONE;
            r_inv_yaw_gain      <= GAIN_ONE;
            r_thrust_floor      <= FLOOR_RESET;
            r_thrust_ceiling    <= CEILING_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_HALF_DIAG_ARM:     r_half_diag_arm     <= i_cfg_data[GAIN_W-1:0];
                REG_INV_HALF_DIAG_ARM: r_inv_half_diag_arm <= i_cfg_data[GAIN_W-1:0];
                REG_YAW_GAIN:          r_yaw_gain          <= i_cfg_data[GAIN_W-1:0];
                REG_INV_YAW_GAIN:      r_inv_yaw_gain      <= i_cfg_data[GAIN_W-1:0];
                REG_THRUST_FLOOR:      r_thrust_floor      <= t_data'(i_cfg_data);
                REG_THRUST_CEILING:    r_thrust_ceiling    <= t_data'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Each stage advances when it is empty or its successor advances.
    assign en5 = !r_v5 || i_out_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // Stage 1: operand sums and gain selection.
    always_comb begin
        t_sum a, b, c, d;
        a = t_sum'(i_force_or_thrust_a);
        b = t_sum'(i_roll_or_thrust_b);
        c = t_sum'(i_pitch_or_thrust_c);
        d = t_sum'(i_yaw_or_thrust_d);
        if (i_command == CMD_UNMIX) begin
            n1_base    = a + b + c + d;
            n1_opd[0]  = a - b - c + d;
            n1_opd[1]  = a + b - c - d;
            n1_opd[2]  = a - b + c - d;
            n1_gain[0] = r_half_diag_arm;
            n1_gain[1] = r_half_diag_arm;
            n1_gain[2] = r_yaw_gain;
        end else begin
            n1_base    = a;
            n1_opd[0]  = b;
            n1_opd[1]  = c;
            n1_opd[2]  = d;
            n1_gain[0] = r_inv_half_diag_arm;
            n1_gain[1] = r_inv_half_diag_arm;
            n1_gain[2] = r_inv_yaw_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_cmd  <= i_command;
            r1_base <= n1_base;
            for (int l = 0; l < NUM_LANES; l++) begin
                r1_opd[l]  <= n1_opd[l];
                r1_gain[l] <= n1_gain[l];
            end
        end
    end

    // Stage 2: high and low partial products of each lane.
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_cmd  <= r1_cmd;
            r2_base <= r1_base;
            for (int l = 0; l < NUM_LANES; l++) begin
                r2_ph[l] <= $signed(r1_opd[l][SUM_W-1:LO_W]) * $signed({1'b0, r1_gain[l]});
                r2_pl[l] <= $signed({1'b0, r1_opd[l][LO_W-1:0]}) * $signed({1'b0, r1_gain[l]});
            end
        end
    end

    // Stage 3: recombine, drop the fraction with floor, saturate.
    always_comb begin
        t_prod full;
        t_prod shifted;
        n3_ovf = 1'b0;
        for (int l = 0; l < NUM_LANES; l++) begin
            full    = (t_prod'(r2_ph[l]) <<< LO_W) + t_prod'(r2_pl[l]);
            shifted = full >>> FRAC_BITS;
            if (shifted > PROD_DATA_MAX) begin
                n3_prod[l] = DATA_MAX;
                n3_ovf     = 1'b1;
            end else if (shifted < PROD_DATA_MIN) begin
                n3_prod[l] = DATA_MIN;
                n3_ovf     = 1'b1;
            end else begin
                n3_prod[l] = shifted[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_cmd  <= r2_cmd;
            r3_base <= r2_base;
            r3_ovf  <= n3_ovf;
            for (int l = 0; l < NUM_LANES; l++) begin
                r3_prod[l] <= n3_prod[l];
            end
        end
    end

    // Stage 4: motor sums divided by four, or force saturation.
    always_comb begin
        t_sum rx, ry, yw;
        t_sum s [NUM_MOTORS];
        rx = t_sum'(r3_prod[0]);
        ry = t_sum'(r3_prod[1]);
        yw = t_sum'(r3_prod[2]);
        s[0] = r3_base + rx + ry + yw;
        s[1] = r3_base - rx + ry - yw;
        s[2] = r3_base - rx - ry + yw;
        s[3] = r3_base + rx - ry - yw;
        n4_ovf = r3_ovf;
        if (r3_cmd == CMD_UNMIX) begin
            if (r3_base > SUM_DATA_MAX) begin
                n4_raw[0] = DATA_MAX;
                n4_ovf    = 1'b1;
            end else if (r3_base < SUM_DATA_MIN) begin
                n4_raw[0] = DATA_MIN;
                n4_ovf    = 1'b1;
            end else begin
                n4_raw[0] = r3_base[DATA_W-1:0];
            end
            for (int m = 1; m < NUM_MOTORS; m++) begin
                n4_raw[m] = r3_prod[m-1];
            end
        end else begin
            for (int m = 0; m < NUM_MOTORS; m++) begin
                n4_raw[m] = t_data'(s[m] >>> 2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_cmd <= r3_cmd;
            r4_ovf <= n4_ovf;
            for (int m = 0; m < NUM_MOTORS; m++) begin
                r4_raw[m] <= n4_raw[m];
            end
        end
    end

    // Stage 5: floor first, then ceiling, with a flag per motor.
    always_comb begin
        t_data t;
        for (int m = 0; m < NUM_MOTORS; m++) begin
            t = r4_raw[m];
            if (r4_cmd == CMD_MIX) begin
                if (t < r_thrust_floor) begin
                    t = r_thrust_floor;
                end
                if (t > r_thrust_ceiling) begin
                    t = r_thrust_ceiling;
                end
            end
            n5_out[m]   = t;
            n5_flags[m] = (t != r4_raw[m]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_ovf   <= r4_ovf;
            r5_flags <= n5_flags;
            for (int m = 0; m < NUM_MOTORS; m++) begin
                r5_out[m] <= n5_out[m];
            end
        end
    end

    assign o_out_valid         = r_v5;
    assign o_thrust_a_or_force = r5_out[0];
    assign o_thrust_b_or_roll  = r5_out[1];
    assign o_thrust_c_or_pitch = r5_out[2];
    assign o_thrust_d_or_yaw   = r5_out[3];
    assign o_clamp_flags       = r5_flags;
    assign o_overflow_flag     = r5_ovf;

endmodule

@@ sim/quad_x_motor_mixer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_test
// Self-checking testbench for the quadrotor X-frame motor mixer. Directed
// words cover the operand extremes, both commands, product and sum
// saturation, clamping, a floor set above the ceiling and writes to unused
// register indexes. Randomized traffic then runs under several register
// settings with random idling on both channels. Every result word is
// checked field by field against an in-order prediction.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_test;
    import qxm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int    STALL_LIMIT  = 4000;
    localparam int    DRAIN_CYCLES = 10;
    localparam int    PHASE_WORDS  = 100;
    localparam int    REPORT_LIMIT = 10;
    localparam t_data Q_UNIT       = 32'sh0001_0000;

    typedef logic signed [35:0]  t_wide;
    typedef logic signed [127:0] t_huge;

    localparam t_huge HUGE_DATA_MAX = DATA_MAX;
    localparam t_huge HUGE_DATA_MIN = DATA_MIN;

    typedef struct packed {
        logic  command;
        t_data a;
        t_data b;
        t_data c;
        t_data d;
    } t_mixer_cmd;

    typedef struct packed {
        t_data      a;
        t_data      b;
        t_data      c;
        t_data      d;
        logic [3:0] clamp;
        logic       ovf;
    } t_mixer_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_command;
    t_data                i_force_or_thrust_a;
    t_data                i_roll_or_thrust_b;
    t_data                i_pitch_or_thrust_c;
    t_data                i_yaw_or_thrust_d;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_data                o_thrust_a_or_force;
    t_data                o_thrust_b_or_roll;
    t_data                o_thrust_c_or_pitch;
    t_data                o_thrust_d_or_yaw;
    logic [3:0]           o_clamp_flags;
    logic                 o_overflow_flag;

    t_gain arm_gain;
    t_gain inv_arm_gain;
    t_gain yaw_k;
    t_gain inv_yaw_k;
    t_data thrust_lo;
    t_data thrust_hi;

    t_mixer_result pending[$];
    int            mismatches;
    logic          full_rate;

    quad_x_motor_mixer u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_command           (i_command),
        .i_force_or_thrust_a (i_force_or_thrust_a),
        .i_roll_or_thrust_b  (i_roll_or_thrust_b),
        .i_pitch_or_thrust_c (i_pitch_or_thrust_c),
        .i_yaw_or_thrust_d   (i_yaw_or_thrust_d),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_thrust_a_or_force (o_thrust_a_or_force),
        .o_thrust_b_or_roll  (o_thrust_b_or_roll),
        .o_thrust_c_or_pitch (o_thrust_c_or_pitch),
        .o_thrust_d_or_yaw   (o_thrust_d_or_yaw),
        .o_clamp_flags       (o_clamp_flags),
        .o_overflow_flag     (o_overflow_flag)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_data saturate_data(input t_huge v, inout logic ovf);
        if (v > HUGE_DATA_MAX) begin
            ovf = 1'b1;
            return DATA_MAX;
        end
        if (v < HUGE_DATA_MIN) begin
            ovf = 1'b1;
            return DATA_MIN;
        end
        return t_data'(v);
    endfunction

    // Full product, floor shift by the fraction width, then saturation.
    function automatic t_data scale_q(input t_wide x, input t_gain g, inout logic ovf);
        t_huge p;
        p = t_huge'(x);
        p = (p * $signed({1'b0, g})) >>> FRAC_BITS;
        return saturate_data(p, ovf);
    endfunction

    function automatic t_mixer_result predict_result(input t_mixer_cmd w);
        t_mixer_result r;
        t_wide         fa, fb, fc, fd, rx, ry, yz;
        t_wide         s [4];
        t_data         raw [4];
        t_data         lim [4];
        logic          ovf;
        ovf = 1'b0;
        fa = t_wide'($signed(w.a));
        fb = t_wide'($signed(w.b));
        fc = t_wide'($signed(w.c));
        fd = t_wide'($signed(w.d));
        r.clamp = '0;
        if (w.command == CMD_MIX) begin
            rx = t_wide'(scale_q(fb, inv_arm_gain, ovf));
            ry = t_wide'(scale_q(fc, inv_arm_gain, ovf));
            yz = t_wide'(scale_q(fd, inv_yaw_k, ovf));
            s[0] = fa + rx + ry + yz;
            s[1] = fa - rx + ry - yz;
            s[2] = fa - rx - ry + yz;
            s[3] = fa + rx - ry - yz;
            for (int i = 0; i < NUM_MOTORS; i++) begin
                raw[i] = t_data'(s[i] >>> 2);
                lim[i] = raw[i];
                if (lim[i] < thrust_lo) lim[i] = thrust_lo;
                if (lim[i] > thrust_hi) lim[i] = thrust_hi;
                r.clamp[i] = (lim[i] != raw[i]);
            end
        end else begin
            lim[0] = saturate_data(fa + fb + fc + fd, ovf);
            lim[1] = scale_q(fa - fb - fc + fd, arm_gain, ovf);
            lim[2] = scale_q(fa + fb - fc - fd, arm_gain, ovf);
            lim[3] = scale_q(fa - fb + fc - fd, yaw_k, ovf);
        end
        r.a = lim[0];
        r.b = lim[1];
        r.c = lim[2];
        r.d = lim[3];
        r.ovf = ovf;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (full_rate) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_data rand_operand();
        t_data v;
        case ($urandom_range(0, 9))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return t_data'($urandom_range(0, 2)) - 1;
            default: begin
                v = $urandom;
                return v >>> $urandom_range(0, 24);
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_gain_data();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return ($urandom & 32'h8000_0000) | $urandom_range(1 << 12, 1 << 19);
        endcase
    endfunction

    function automatic t_mixer_cmd make_word(input logic cmd, input t_data a, input t_data b,
                                             input t_data c, input t_data d);
        t_mixer_cmd w;
        w.command = cmd;
        w.a = a;
        w.b = b;
        w.c = c;
        w.d = d;
        return w;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            REG_HALF_DIAG_ARM:     arm_gain     = value[GAIN_W-1:0];
            REG_INV_HALF_DIAG_ARM: inv_arm_gain = value[GAIN_W-1:0];
            REG_YAW_GAIN:          yaw_k        = value[GAIN_W-1:0];
            REG_INV_YAW_GAIN:      inv_yaw_k    = value[GAIN_W-1:0];
            REG_THRUST_FLOOR:      thrust_lo    = value;
            REG_THRUST_CEILING:    thrust_hi    = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_word(input t_mixer_cmd w);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_command           <= w.command;
        i_force_or_thrust_a <= w.a;
        i_roll_or_thrust_b  <= w.b;
        i_pitch_or_thrust_c <= w.c;
        i_yaw_or_thrust_d   <= w.d;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        pending.push_back(predict_result(w));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_word(make_word(CMD_MIX, 4 * Q_UNIT, 0, 0, 0));
        send_word(make_word(CMD_MIX, 0, Q_UNIT, -Q_UNIT, Q_UNIT));
        send_word(make_word(CMD_UNMIX, Q_UNIT, 2 * Q_UNIT, 3 * Q_UNIT, 4 * Q_UNIT));
    endtask

    task automatic test_mix_extremes();
        send_word(make_word(CMD_MIX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX));
        send_word(make_word(CMD_MIX, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN));
        send_word(make_word(CMD_MIX, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN));
        wait_drained();
        write_reg(REG_INV_HALF_DIAG_ARM, '1);
        write_reg(REG_INV_YAW_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_THRUST_FLOOR, DATA_MIN);
        write_reg(REG_THRUST_CEILING, DATA_MAX);
        send_word(make_word(CMD_MIX, 0, DATA_MAX, DATA_MIN, DATA_MAX));
        send_word(make_word(CMD_MIX, -1, 1, -1, 1));
        send_word(make_word(CMD_MIX, DATA_MIN, -Q_UNIT, Q_UNIT, -Q_UNIT));
    endtask

    task automatic test_unmix_extremes();
        send_word(make_word(CMD_UNMIX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX));
        send_word(make_word(CMD_UNMIX, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN));
        wait_drained();
        write_reg(REG_HALF_DIAG_ARM, 32'h7FFF_FFFF);
        write_reg(REG_YAW_GAIN, '1);
        send_word(make_word(CMD_UNMIX, DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX));
        send_word(make_word(CMD_UNMIX, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX));
        send_word(make_word(CMD_UNMIX, -1, 0, 0, 0));
        send_word(make_word(CMD_UNMIX, 0, 0, 0, 0));
    endtask

    task automatic test_floor_above_ceiling();
        wait_drained();
        write_reg(REG_INV_HALF_DIAG_ARM, GAIN_ONE);
        write_reg(REG_INV_YAW_GAIN, GAIN_ONE);
        write_reg(REG_THRUST_FLOOR, 5 * Q_UNIT);
        write_reg(REG_THRUST_CEILING, -Q_UNIT);
        send_word(make_word(CMD_MIX, 0, 0, 0, 0));
        send_word(make_word(CMD_MIX, 8 * Q_UNIT, Q_UNIT, Q_UNIT, Q_UNIT));
        wait_drained();
        write_reg(REG_THRUST_FLOOR, Q_UNIT);
        write_reg(REG_THRUST_CEILING, Q_UNIT);
        send_word(make_word(CMD_MIX, 4 * Q_UNIT, Q_UNIT, 0, 0));
        send_word(make_word(CMD_UNMIX, DATA_MAX, 0, 0, 0));
    endtask

    task automatic test_spare_registers();
        wait_drained();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '0);
        send_word(make_word(CMD_MIX, 2 * Q_UNIT, Q_UNIT, 0, -Q_UNIT));
        send_word(make_word(CMD_UNMIX, Q_UNIT, 0, Q_UNIT, 0));
    endtask

    task automatic test_random_traffic();
        t_mixer_cmd w;
        int         lo;
        for (int phase = 0; phase < 5; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    write_reg(REG_HALF_DIAG_ARM, GAIN_ONE);
                    write_reg(REG_INV_HALF_DIAG_ARM, GAIN_ONE);
                    write_reg(REG_YAW_GAIN, GAIN_ONE);
                    write_reg(REG_INV_YAW_GAIN, GAIN_ONE);
                    write_reg(REG_THRUST_FLOOR, FLOOR_RESET);
                    write_reg(REG_THRUST_CEILING, CEILING_RESET);
                end
                1: begin
                    write_reg(REG_HALF_DIAG_ARM, 32'h7FFF_FFFF);
                    write_reg(REG_INV_HALF_DIAG_ARM, 32'h7FFF_FFFF);
                    write_reg(REG_YAW_GAIN, 32'h7FFF_FFFF);
                    write_reg(REG_INV_YAW_GAIN, 32'h7FFF_FFFF);
                    write_reg(REG_THRUST_FLOOR, DATA_MIN);
                    write_reg(REG_THRUST_CEILING, DATA_MAX);
                end
                2: begin
                    write_reg(REG_HALF_DIAG_ARM, '0);
                    write_reg(REG_INV_HALF_DIAG_ARM, '0);
                    write_reg(REG_YAW_GAIN, '0);
                    write_reg(REG_INV_YAW_GAIN, '0);
                    write_reg(REG_THRUST_FLOOR, -Q_UNIT);
                    write_reg(REG_THRUST_CEILING, Q_UNIT);
                end
                default: begin
                    write_reg(REG_HALF_DIAG_ARM, rand_gain_data());
                    write_reg(REG_INV_HALF_DIAG_ARM, rand_gain_data());
                    write_reg(REG_YAW_GAIN, rand_gain_data());
                    write_reg(REG_INV_YAW_GAIN, rand_gain_data());
                    lo = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                    write_reg(REG_THRUST_FLOOR, lo);
                    if ($urandom_range(0, 7) == 0)
                        write_reg(REG_THRUST_CEILING, lo - int'($urandom_range(1, 1 << 20)));
                    else
                        write_reg(REG_THRUST_CEILING, lo + int'($urandom_range(0, 1 << 22)));
                end
            endcase
            full_rate = (phase == 2);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                w = make_word($urandom_range(0, 1) ? CMD_UNMIX : CMD_MIX, rand_operand(),
                              rand_operand(), rand_operand(), rand_operand());
                send_word(w);
            end
            full_rate = 1'b0;
        end
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin : receiver
            int stall;
            int run;
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run - 1) @(negedge i_clk);
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_mixer_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result word with no word outstanding", $time);
            end else begin
                want = pending.pop_front();
                compare_field("thrust_a_or_force", want.a, o_thrust_a_or_force);
                compare_field("thrust_b_or_roll", want.b, o_thrust_b_or_roll);
                compare_field("thrust_c_or_pitch", want.c, o_thrust_c_or_pitch);
                compare_field("thrust_d_or_yaw", want.d, o_thrust_d_or_yaw);
                compare_field("clamp_flags", 32'(want.clamp), 32'(o_clamp_flags));
                compare_field("overflow_flag", 32'(want.ovf), 32'(o_overflow_flag));
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || i_cfg_wr_en)
                idle = 0;
            else
                idle++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_index         = REG_HALF_DIAG_ARM;
        i_cfg_data          = '0;
        i_in_valid          = 1'b0;
        i_command           = CMD_MIX;
        i_force_or_thrust_a = '0;
        i_roll_or_thrust_b  = '0;
        i_pitch_or_thrust_c = '0;
        i_yaw_or_thrust_d   = '0;
        full_rate           = 1'b0;
        mismatches          = 0;
        arm_gain            = GAIN_ONE;
        inv_arm_gain        = GAIN_ONE;
        yaw_k               = GAIN_ONE;
        inv_yaw_k           = GAIN_ONE;
        thrust_lo           = FLOOR_RESET;
        thrust_hi           = CEILING_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_mix_extremes();
        test_unmix_extremes();
        test_floor_above_ceiling();
        test_spare_registers();
        test_random_traffic();
        wait_drained();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
